>>> hdl/lewb_pkg.sv
// Shared types and constants for the line editor core.
// No dependencies; used by lewb_ctrl and line_editor_with_backspace_core.
package lewb_pkg;

  localparam int unsigned KEY_W = 8;
  localparam int unsigned LEN_W = 6;
  localparam int unsigned ADDR_W = 4;
  localparam int unsigned DATA_W = 32;

  localparam logic [KEY_W-1:0] KEY_BACKSPACE = 8'd8;

  // Register indexes (paddr[3:2])
  localparam logic [1:0] REG_TERM_FIRST  = 2'd0;
  localparam logic [1:0] REG_TERM_SECOND = 2'd1;
  localparam logic [1:0] REG_MAX_LEN     = 2'd2;

  localparam logic [KEY_W-1:0] TERM_FIRST_RST  = 8'd32;
  localparam logic [KEY_W-1:0] TERM_SECOND_RST = 8'd10;
  localparam logic [LEN_W-1:0] MAX_LEN_RST     = 6'd63;

  typedef enum logic [1:0] {
    KIND_ECHO = 2'd0,
    KIND_LINE = 2'd1,
    KIND_TERM = 2'd2
  } kind_e;

  typedef enum logic {
    ST_IDLE  = 1'b0,
    ST_DRAIN = 1'b1
  } state_e;

  typedef struct packed {
    logic [KEY_W-1:0] term_first;
    logic [KEY_W-1:0] term_second;
    logic [LEN_W-1:0] limit;   // max_len clamped to the store depth
  } cfg_t;

endpackage

>>> hdl/lewb_ram.sv
// Line store: single write port, single read port, registered read data.
// Read data holds while no read is issued. No dependencies.
module lewb_ram #(
  parameter int unsigned DEPTH = 63,
  parameter int unsigned AW    = 6,
  parameter int unsigned DW    = 8
) (
  input  logic          clk_i,
  input  logic          we_i,
  input  logic [AW-1:0] waddr_i,
  input  logic [DW-1:0] wdata_i,
  input  logic          re_i,
  input  logic [AW-1:0] raddr_i,
  output logic [DW-1:0] rdata_o
);

  logic [DW-1:0] mem_q [DEPTH];
  logic [DW-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

>>> hdl/lewb_ctrl.sv
// Key handling, line length and line readout sequencer with the result register.
// Depends on lewb_pkg and lewb_ram.
module lewb_ctrl #(
  parameter int unsigned MAX_LINE = 63
) (
  input  logic                       clk_i,
  input  logic                       rst_ni,
  input  lewb_pkg::cfg_t             cfg_i,
  input  logic                       in_valid_i,
  output logic                       in_stall_o,
  input  logic [lewb_pkg::KEY_W-1:0] key_code_i,
  output logic                       out_valid_o,
  input  logic                       out_stall_i,
  output logic [1:0]                 kind_o,
  output logic [lewb_pkg::KEY_W-1:0] out_char_o,
  output logic [lewb_pkg::LEN_W-1:0] line_len_o,
  output logic                       last_o
);

  localparam int unsigned IDX_W = (MAX_LINE > 1) ? $clog2(MAX_LINE) : 1;

  lewb_pkg::state_e state_q, state_d;
  logic [lewb_pkg::LEN_W-1:0] len_q, len_d;
  logic [lewb_pkg::LEN_W-1:0] rd_idx_q, rd_idx_d;
  logic                       avail_q, avail_d;   // rdata holds an unsent char
  logic [lewb_pkg::KEY_W-1:0] term_q, term_d;

  logic                       out_valid_q, out_valid_d;
  lewb_pkg::kind_e            out_kind_q, out_kind_d;
  logic [lewb_pkg::KEY_W-1:0] out_char_q, out_char_d;
  logic [lewb_pkg::LEN_W-1:0] out_len_q, out_len_d;
  logic                       out_last_q, out_last_d;

  logic                       out_free, accept, is_term;
  logic                       mem_we, mem_re, out_load;
  logic [lewb_pkg::KEY_W-1:0] mem_rdata;

  assign out_free = !out_valid_q || !out_stall_i;
  assign accept   = in_valid_i && (state_q == lewb_pkg::ST_IDLE) && out_free;
  assign is_term  = (key_code_i == cfg_i.term_first) || (key_code_i == cfg_i.term_second);
  assign in_stall_o = !((state_q == lewb_pkg::ST_IDLE) && out_free);

  always_comb begin
    state_d     = state_q;
    len_d       = len_q;
    rd_idx_d    = rd_idx_q;
    avail_d     = avail_q;
    term_d      = term_q;
    out_valid_d = out_valid_q && out_stall_i;
    out_kind_d  = out_kind_q;
    out_char_d  = out_char_q;
    out_len_d   = out_len_q;
    out_last_d  = out_last_q;
    mem_we      = 1'b0;
    mem_re      = 1'b0;
    out_load    = 1'b0;

    unique case (state_q)
      lewb_pkg::ST_IDLE: begin
        if (accept) begin
          if (is_term) begin
            term_d   = key_code_i;
            rd_idx_d = '0;
            avail_d  = 1'b0;
            state_d  = lewb_pkg::ST_DRAIN;
          end else begin
            if (key_code_i == lewb_pkg::KEY_BACKSPACE) begin
              if (len_q != '0) begin
                len_d = len_q - 1'b1;
              end
            end else if (len_q < cfg_i.limit) begin
              mem_we = 1'b1;
              len_d  = len_q + 1'b1;
            end
            out_valid_d = 1'b1;
            out_kind_d  = lewb_pkg::KIND_ECHO;
            out_char_d  = key_code_i;
            out_len_d   = len_d;
            out_last_d  = 1'b1;
          end
        end
      end
      lewb_pkg::ST_DRAIN: begin
        // one read in flight at most; rdata waits until the result register frees
        out_load = avail_q && out_free;
        mem_re   = (rd_idx_q < len_q) && (!avail_q || out_load);
        if (out_load) begin
          out_valid_d = 1'b1;
          out_kind_d  = lewb_pkg::KIND_LINE;
          out_char_d  = mem_rdata;
          out_len_d   = '0;
          out_last_d  = 1'b0;
        end
        if (mem_re) begin
          rd_idx_d = rd_idx_q + 1'b1;
          avail_d  = 1'b1;
        end else if (out_load) begin
          avail_d = 1'b0;
        end
        if ((rd_idx_q == len_q) && !avail_q && out_free) begin
          out_valid_d = 1'b1;
          out_kind_d  = lewb_pkg::KIND_TERM;
          out_char_d  = term_q;
          out_len_d   = '0;
          out_last_d  = 1'b1;
          len_d       = '0;
          state_d     = lewb_pkg::ST_IDLE;
        end
      end
      default: state_d = lewb_pkg::ST_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= lewb_pkg::ST_IDLE;
      len_q       <= '0;
      rd_idx_q    <= '0;
      avail_q     <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      len_q       <= len_d;
      rd_idx_q    <= rd_idx_d;
      avail_q     <= avail_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    term_q     <= term_d;
    out_kind_q <= out_kind_d;
    out_char_q <= out_char_d;
    out_len_q  <= out_len_d;
    out_last_q <= out_last_d;
  end

  lewb_ram #(
    .DEPTH (MAX_LINE),
    .AW    (IDX_W),
    .DW    (lewb_pkg::KEY_W)
  ) u_ram (
    .clk_i   (clk_i),
    .we_i    (mem_we),
    .waddr_i (len_q[IDX_W-1:0]),
    .wdata_i (key_code_i),
    .re_i    (mem_re),
    .raddr_i (rd_idx_q[IDX_W-1:0]),
    .rdata_o (mem_rdata)
  );

  assign out_valid_o = out_valid_q;
  assign kind_o      = 2'(out_kind_q);
  assign out_char_o  = out_char_q;
  assign line_len_o  = out_len_q;
  assign last_o      = out_last_q;

endmodule

>>> hdl/line_editor_with_backspace_core.sv
// Line editor top level: APB register file and the key/readout controller.
// Depends on lewb_pkg and lewb_ctrl.
//
//  channel | direction | handshake               | payload
//  --------+-----------+-------------------------+-----------------------------------
//  key in  | input     | in_valid_i / in_stall_o | key_code_i
//  result  | output    | out_valid_o/out_stall_i | kind_o, out_char_o, line_len_o, last_o
//  config  | APB       | psel/penable/pready     | paddr, pwdata, prdata
//
// A plain key or backspace gives its echo beat in the cycle after it is taken.
// A terminator gives one line beat per kept character, then its terminator beat:
// the line RAM is read one entry per cycle while the result register is free, and
// each beat leaves through the result register.
// Reset empties the line and loads the register defaults; the line RAM is not cleared.
// An output stall holds the readout in place; no key is taken until the terminator beat.
module line_editor_with_backspace_core #(
  parameter int unsigned MAX_LINE = 63
) (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  logic                        psel,
  input  logic                        penable,
  input  logic                        pwrite,
  input  logic [lewb_pkg::ADDR_W-1:0] paddr,
  input  logic [lewb_pkg::DATA_W-1:0] pwdata,
  output logic [lewb_pkg::DATA_W-1:0] prdata,
  output logic                        pready,
  input  logic                        in_valid_i,
  output logic                        in_stall_o,
  input  logic [lewb_pkg::KEY_W-1:0]  key_code_i,
  output logic                        out_valid_o,
  input  logic                        out_stall_i,
  output logic [1:0]                  kind_o,
  output logic [lewb_pkg::KEY_W-1:0]  out_char_o,
  output logic [lewb_pkg::LEN_W-1:0]  line_len_o,
  output logic                        last_o
);

  localparam logic [lewb_pkg::LEN_W-1:0] MaxLineL = lewb_pkg::LEN_W'(MAX_LINE);

  logic [lewb_pkg::KEY_W-1:0] term_first_q, term_first_d;
  logic [lewb_pkg::KEY_W-1:0] term_second_q, term_second_d;
  logic [lewb_pkg::LEN_W-1:0] max_len_q, max_len_d;
  logic                       wr_en;
  logic [1:0]                 reg_idx;
  lewb_pkg::cfg_t             cfg;

  assign pready  = 1'b1;
  assign wr_en   = psel && penable && pwrite && pready;
  assign reg_idx = paddr[3:2];

  always_comb begin
    term_first_d  = term_first_q;
    term_second_d = term_second_q;
    max_len_d     = max_len_q;
    if (wr_en) begin
      unique case (reg_idx)
        lewb_pkg::REG_TERM_FIRST:  term_first_d  = pwdata[lewb_pkg::KEY_W-1:0];
        lewb_pkg::REG_TERM_SECOND: term_second_d = pwdata[lewb_pkg::KEY_W-1:0];
        lewb_pkg::REG_MAX_LEN:     max_len_d     = pwdata[lewb_pkg::LEN_W-1:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    unique case (reg_idx)
      lewb_pkg::REG_TERM_FIRST:  prdata = lewb_pkg::DATA_W'(term_first_q);
      lewb_pkg::REG_TERM_SECOND: prdata = lewb_pkg::DATA_W'(term_second_q);
      lewb_pkg::REG_MAX_LEN:     prdata = lewb_pkg::DATA_W'(max_len_q);
      default:                   prdata = '0;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      term_first_q  <= lewb_pkg::TERM_FIRST_RST;
      term_second_q <= lewb_pkg::TERM_SECOND_RST;
      max_len_q     <= lewb_pkg::MAX_LEN_RST;
    end else begin
      term_first_q  <= term_first_d;
      term_second_q <= term_second_d;
      max_len_q     <= max_len_d;
    end
  end

  assign cfg.term_first  = term_first_q;
  assign cfg.term_second = term_second_q;
  assign cfg.limit       = (max_len_q > MaxLineL) ? MaxLineL : max_len_q;

  lewb_ctrl #(
    .MAX_LINE (MAX_LINE)
  ) u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_i       (cfg),
    .in_valid_i  (in_valid_i),
    .in_stall_o  (in_stall_o),
    .key_code_i  (key_code_i),
    .out_valid_o (out_valid_o),
    .out_stall_i (out_stall_i),
    .kind_o      (kind_o),
    .out_char_o  (out_char_o),
    .line_len_o  (line_len_o),
    .last_o      (last_o)
  );

endmodule

>>> dv/tb_line_editor_with_backspace_core.sv
// Self-checking testbench for line_editor_with_backspace_core: a directed table, then random lines.
// Every result beat is checked against an in-bench line model under random idling and stalls.
// Depends on lewb_pkg and the line_editor_with_backspace_core RTL.
module tb_line_editor_with_backspace_core;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int unsigned DEPTH     = 63;
  localparam logic [1:0]  REG_SPARE = 2'd3;  // unmapped register slot, writes are dropped
  localparam int unsigned PHASE_MIN = 8;

  typedef struct packed {
    lewb_pkg::kind_e            kind;
    logic [lewb_pkg::KEY_W-1:0] ch;
    logic [lewb_pkg::LEN_W-1:0] len;
    logic                       last;
  } beat_t;

  typedef struct {
    bit                          is_cfg;
    logic [1:0]                  idx;
    logic [lewb_pkg::DATA_W-1:0] data;
    logic [lewb_pkg::KEY_W-1:0]  key;
    bit                          typed;
    beat_t                       want;
  } row_t;

  typedef struct {
    bit    typed;
    beat_t want;
  } key_tag_t;

  logic                          clk_i;
  logic                          rst_ni;
  logic                          psel;
  logic                          penable;
  logic                          pwrite;
  logic [lewb_pkg::ADDR_W-1:0]   paddr;
  logic [lewb_pkg::DATA_W-1:0]   pwdata;
  logic [lewb_pkg::DATA_W-1:0]   prdata;
  logic                          pready;
  logic                          in_valid_i;
  logic                          in_stall_o;
  logic [lewb_pkg::KEY_W-1:0]    key_code_i;
  logic                          out_valid_o;
  logic                          out_stall_i;
  logic [1:0]                    kind_o;
  logic [lewb_pkg::KEY_W-1:0]    out_char_o;
  logic [lewb_pkg::LEN_W-1:0]    line_len_o;
  logic                          last_o;

  // line model state
  logic [lewb_pkg::KEY_W-1:0]    line_buf [DEPTH];
  logic [lewb_pkg::LEN_W-1:0]    line_cnt;
  logic [lewb_pkg::KEY_W-1:0]    term_a;
  logic [lewb_pkg::KEY_W-1:0]    term_b;
  logic [lewb_pkg::LEN_W-1:0]    keep_max;

  beat_t               beats_due [$];
  row_t                dir_rows [$];
  key_tag_t            key_tag;

  int                  err_cnt;
  int                  keys_taken;
  int                  beats_seen;
  int                  lines_ended;
  int                  cfg_writes;
  int                  burst_left;

  line_editor_with_backspace_core dut (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .psel        (psel),
    .penable     (penable),
    .pwrite      (pwrite),
    .paddr       (paddr),
    .pwdata      (pwdata),
    .prdata      (prdata),
    .pready      (pready),
    .in_valid_i  (in_valid_i),
    .in_stall_o  (in_stall_o),
    .key_code_i  (key_code_i),
    .out_valid_o (out_valid_o),
    .out_stall_i (out_stall_i),
    .kind_o      (kind_o),
    .out_char_o  (out_char_o),
    .line_len_o  (line_len_o),
    .last_o      (last_o)
  );

  initial begin
    clk_i = 1'b0;
    forever #5 clk_i = ~clk_i;
  end

  initial begin
    #2000000;
    $display("TB_ERROR");
    $finish;
  end

  // Apply one accepted key to the line model and queue the beats it causes.
  function automatic void edit_line(logic [lewb_pkg::KEY_W-1:0] key);
    if (key == term_a || key == term_b) begin
      for (int i = 0; i < int'(line_cnt); i++) begin
        beats_due.push_back({lewb_pkg::KIND_LINE, line_buf[i], 6'd0, 1'b0});
      end
      beats_due.push_back({lewb_pkg::KIND_TERM, key, 6'd0, 1'b1});
      line_cnt = '0;
      lines_ended++;
    end else begin
      if (key == lewb_pkg::KEY_BACKSPACE) begin
        if (line_cnt > 0) line_cnt = line_cnt - 1'b1;
      end else if (line_cnt < keep_max) begin
        line_buf[line_cnt] = key;
        line_cnt = line_cnt + 1'b1;
      end
      beats_due.push_back({lewb_pkg::KIND_ECHO, key, line_cnt, 1'b1});
    end
  endfunction

  // Monitor: check output beats, track register writes, predict on accepted keys.
  always @(posedge clk_i) begin : mon
    beat_t got;
    beat_t due;
    if (rst_ni) begin
      if (out_valid_o && !out_stall_i) begin
        got = {kind_o, out_char_o, line_len_o, last_o};
        beats_seen++;
        if (beats_due.size() == 0) begin
          err_cnt++;
          $display("%0t: unexpected beat kind=%0d char=%02h len=%0d last=%0b", $realtime,
                   got.kind, got.ch, got.len, got.last);
        end else begin
          due = beats_due.pop_front();
          if (got !== due) begin
            err_cnt++;
            $display("%0t: beat mismatch: expected kind=%0d char=%02h len=%0d last=%0b",
                     $realtime, due.kind, due.ch, due.len, due.last);
            $display("%0t:                actual   kind=%0d char=%02h len=%0d last=%0b",
                     $realtime, got.kind, got.ch, got.len, got.last);
          end
        end
      end
      if (psel && penable && pwrite && pready) begin
        case (paddr[3:2])
          lewb_pkg::REG_TERM_FIRST:  term_a = pwdata[lewb_pkg::KEY_W-1:0];
          lewb_pkg::REG_TERM_SECOND: term_b = pwdata[lewb_pkg::KEY_W-1:0];
          lewb_pkg::REG_MAX_LEN:     keep_max = pwdata[lewb_pkg::LEN_W-1:0];
          default: ;
        endcase
      end
      if (in_valid_i && !in_stall_o) begin
        keys_taken++;
        edit_line(key_code_i);
        if (key_tag.typed && beats_due[$] !== key_tag.want) begin
          err_cnt++;
          $display("%0t: table expects kind=%0d char=%02h len=%0d, line model has %0d %02h %0d",
                   $realtime, key_tag.want.kind, key_tag.want.ch, key_tag.want.len,
                   beats_due[$].kind, beats_due[$].ch, beats_due[$].len);
        end
      end
    end
  end

  // Receiver: stall in runs of varying density, including clean and fully stalled runs.
  initial begin : rx_stall
    int run_left;
    int mode;
    run_left    = 0;
    mode        = 0;
    out_stall_i = 1'b0;
    forever begin
      @(negedge clk_i);
      if (run_left == 0) begin
        mode     = $urandom_range(0, 3);
        run_left = $urandom_range(1, 40);
      end
      run_left--;
      case (mode)
        0:       out_stall_i <= 1'b0;
        1:       out_stall_i <= ($urandom_range(0, 99) < 30);
        2:       out_stall_i <= ($urandom_range(0, 99) < 75);
        default: out_stall_i <= 1'b1;
      endcase
    end
  end

  task automatic send_key(input logic [lewb_pkg::KEY_W-1:0] k, input bit typed,
                          input beat_t want);
    int gap;
    if (burst_left == 0) begin
      gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 6);
      repeat (gap) begin
        @(negedge clk_i);
        in_valid_i <= 1'b0;
      end
      burst_left = $urandom_range(1, 20);
    end
    burst_left--;
    @(negedge clk_i);
    key_tag.typed = typed;
    key_tag.want  = want;
    in_valid_i <= 1'b1;
    key_code_i <= k;
    do @(posedge clk_i); while (in_stall_o);
  endtask

  task automatic drain_results();
    @(negedge clk_i);
    in_valid_i <= 1'b0;
    while (beats_due.size() != 0) @(posedge clk_i);
    repeat (4) @(posedge clk_i);
  endtask

  task automatic apb_write(input logic [1:0] idx, input logic [lewb_pkg::DATA_W-1:0] data);
    @(negedge clk_i);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= {idx, 2'b00};
    pwdata  <= data;
    @(negedge clk_i);
    penable <= 1'b1;
    do @(posedge clk_i); while (!pready);
    @(negedge clk_i);
    psel    <= 1'b0;
    penable <= 1'b0;
    pwrite  <= 1'b0;
    cfg_writes++;
  endtask

  function automatic void add_key(logic [lewb_pkg::KEY_W-1:0] k);
    row_t r;
    r = '{is_cfg: 1'b0, idx: '0, data: '0, key: k, typed: 1'b0, want: '0};
    dir_rows.push_back(r);
  endfunction

  function automatic void add_chk(logic [lewb_pkg::KEY_W-1:0] k, lewb_pkg::kind_e kd,
                                  logic [lewb_pkg::KEY_W-1:0] c,
                                  logic [lewb_pkg::LEN_W-1:0] l);
    row_t r;
    r = '{is_cfg: 1'b0, idx: '0, data: '0, key: k, typed: 1'b1, want: {kd, c, l, 1'b1}};
    dir_rows.push_back(r);
  endfunction

  function automatic void add_cfg(logic [1:0] idx, logic [lewb_pkg::DATA_W-1:0] data);
    row_t r;
    r = '{is_cfg: 1'b1, idx: idx, data: data, key: '0, typed: 1'b0, want: '0};
    dir_rows.push_back(r);
  endfunction

  // Random line character that neither ends the line nor erases; mostly printable.
  function automatic logic [lewb_pkg::KEY_W-1:0] fresh_char();
    logic [lewb_pkg::KEY_W-1:0] c;
    do begin
      c = ($urandom_range(0, 3) != 0) ? 8'($urandom_range(33, 126)) : 8'($urandom_range(0, 255));
    end while (c == term_a || c == term_b || c == lewb_pkg::KEY_BACKSPACE);
    return c;
  endfunction

  initial begin : main
    int n;
    int r;
    int sent;
    bit paused;
    logic [lewb_pkg::KEY_W-1:0] tf;
    logic [lewb_pkg::KEY_W-1:0] ts;
    logic [lewb_pkg::LEN_W-1:0] ml;

    rst_ni      = 1'b0;
    psel        = 1'b0;
    penable     = 1'b0;
    pwrite      = 1'b0;
    paddr       = '0;
    pwdata      = '0;
    in_valid_i  = 1'b0;
    key_code_i  = '0;
    key_tag     = '{typed: 1'b0, want: '0};
    line_cnt    = '0;
    term_a      = lewb_pkg::TERM_FIRST_RST;
    term_b      = lewb_pkg::TERM_SECOND_RST;
    keep_max    = lewb_pkg::MAX_LEN_RST;
    err_cnt     = 0;
    keys_taken  = 0;
    beats_seen  = 0;
    lines_ended = 0;
    cfg_writes  = 0;
    burst_left  = 0;
    paused      = 1'b0;
    for (int i = 0; i < DEPTH; i++) line_buf[i] = '0;

    // reset defaults: terminators space and newline, room for 63
    add_chk(lewb_pkg::KEY_BACKSPACE, lewb_pkg::KIND_ECHO, lewb_pkg::KEY_BACKSPACE,
            6'd0);                                           // erase on empty line
    add_chk(8'h41, lewb_pkg::KIND_ECHO, 8'h41, 6'd1);
    add_chk(8'hFF, lewb_pkg::KIND_ECHO, 8'hFF, 6'd2);
    add_chk(8'h00, lewb_pkg::KIND_ECHO, 8'h00, 6'd3);
    add_chk(lewb_pkg::KEY_BACKSPACE, lewb_pkg::KIND_ECHO, lewb_pkg::KEY_BACKSPACE, 6'd2);
    add_chk(8'd10, lewb_pkg::KIND_TERM, 8'd10, 6'd0);
    add_chk(8'd32, lewb_pkg::KIND_TERM, 8'd32, 6'd0);        // terminator alone
    // one-character line; upper data bits must be dropped
    add_cfg(lewb_pkg::REG_MAX_LEN, 32'hFFFF_FFC1);
    add_chk(8'h61, lewb_pkg::KIND_ECHO, 8'h61, 6'd1);
    add_chk(8'h62, lewb_pkg::KIND_ECHO, 8'h62, 6'd1);        // full: echoed, not kept
    add_key(8'd10);
    // backspace as both terminators, nothing kept
    add_cfg(lewb_pkg::REG_TERM_FIRST, 32'h0000_0008);
    add_cfg(lewb_pkg::REG_TERM_SECOND, 32'hABCD_0008);
    add_cfg(lewb_pkg::REG_MAX_LEN, 32'h0000_0000);
    add_chk(8'h55, lewb_pkg::KIND_ECHO, 8'h55, 6'd0);
    add_chk(8'd32, lewb_pkg::KIND_ECHO, 8'd32, 6'd0);
    add_chk(lewb_pkg::KEY_BACKSPACE, lewb_pkg::KIND_TERM, lewb_pkg::KEY_BACKSPACE, 6'd0);
    // extreme key codes as terminators; the spare slot must not change anything
    add_cfg(lewb_pkg::REG_MAX_LEN, 32'h0000_003F);
    add_cfg(lewb_pkg::REG_TERM_FIRST, 32'h0000_0000);
    add_cfg(lewb_pkg::REG_TERM_SECOND, 32'hFFFF_FFFF);
    add_cfg(REG_SPARE, 32'h0000_0011);
    add_chk(8'h7F, lewb_pkg::KIND_ECHO, 8'h7F, 6'd1);
    add_chk(8'h80, lewb_pkg::KIND_ECHO, 8'h80, 6'd2);
    add_chk(8'd10, lewb_pkg::KIND_ECHO, 8'd10, 6'd3);
    add_chk(lewb_pkg::KEY_BACKSPACE, lewb_pkg::KIND_ECHO, lewb_pkg::KEY_BACKSPACE, 6'd2);
    add_key(8'hFF);
    add_chk(8'h00, lewb_pkg::KIND_TERM, 8'h00, 6'd0);

    repeat (6) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni <= 1'b1;
    repeat (2) @(posedge clk_i);

    foreach (dir_rows[i]) begin
      if (dir_rows[i].is_cfg) begin
        drain_results();
        apb_write(dir_rows[i].idx, dir_rows[i].data);
      end else begin
        send_key(dir_rows[i].key, dir_rows[i].typed, dir_rows[i].want);
      end
    end

    for (int ph = 0; ph < 4; ph++) begin
      drain_results();
      tf = 8'($urandom_range(0, 255));
      ts = 8'($urandom_range(0, 255));
      case (ph)
        0:       ml = 6'd63;
        1:       begin ml = 6'd1; ts = tf; end
        2:       ml = 6'($urandom_range(1, 12));
        default: ml = 6'($urandom_range(1, 63));
      endcase
      apb_write(lewb_pkg::REG_TERM_FIRST, {24'($urandom), tf});
      apb_write(lewb_pkg::REG_TERM_SECOND, {24'($urandom), ts});
      apb_write(lewb_pkg::REG_MAX_LEN, {26'($urandom), ml});
      if (ph == 0) begin
        // overfill a full-size line, then read it all out
        repeat (DEPTH + 2) send_key(fresh_char(), 1'b0, '0);
        send_key(($urandom_range(0, 1) != 0) ? term_a : term_b, 1'b0, '0);
      end
      sent = 0;
      while (sent < PHASE_MIN) begin
        n = $urandom_range(0, (int'(ml) < 10) ? int'(ml) + 2 : 12);
        for (int i = 0; i < n; i++) begin
          r = $urandom_range(0, 9);
          if (r < 7) send_key(fresh_char(), 1'b0, '0);
          else if (r < 9) send_key(lewb_pkg::KEY_BACKSPACE, 1'b0, '0);
          else send_key(8'($urandom_range(0, 255)), 1'b0, '0);
        end
        sent += n;
        // some lines run on into the next one unterminated
        if ($urandom_range(0, 5) != 0) begin
          send_key(($urandom_range(0, 1) != 0) ? term_a : term_b, 1'b0, '0);
          sent++;
        end
        if (ph == 2 && !paused && sent > PHASE_MIN / 2) begin
          drain_results();
          paused = 1'b1;
        end
      end
    end

    drain_results();
    repeat (16) @(posedge clk_i);
    $display("Run: %0d keys, %0d result beats checked, %0d lines ended, %0d register writes.",
             keys_taken, beats_seen, lines_ended, cfg_writes);
    $display("Covered erase on empty/full lines, backspace and shared terminators, limits 0..63.");
    if (err_cnt == 0) begin
      $display("TB_OK");
    end else begin
      $display("TB_ERROR");
    end
    $finish;
  end

endmodule
